/* sv/sparse_matvec_row_mac_core_assert.svh */
// Assertion macros for the sparse row multiply-accumulate core.
`ifndef SPARSE_MATVEC_ROW_MAC_CORE_ASSERT_SVH
`define SPARSE_MATVEC_ROW_MAC_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SMRM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smrm assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SMRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smrm assertion failed");

`endif

/* sv/smrm_pkg.sv */
`default_nettype none
package smrm_pkg;

    localparam int VEC_DEPTH = 64;
    localparam int VEC_AW    = 6;
    localparam int ROWLEN_W  = 7;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 40;
    localparam int ROWIDX_W  = 6;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_NONZERO = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [VEC_AW-1:0]       vec_index;
        logic signed [VAL_W-1:0] vec_value;
        logic signed [VAL_W-1:0] mat_value;
        logic [VEC_AW-1:0]       mat_col;
        logic [ROWLEN_W-1:0]     row_len;
    } req_t;

    typedef struct packed {
        logic [ROWIDX_W-1:0]     row_id;
        logic signed [SUM_W-1:0] partial_sum;
        logic                    row_done;
        logic                    bad_row_len;
    } rsp_t;

    typedef struct packed {
        logic                clear;
        logic                bad;
        logic                done;
        logic [ROWIDX_W-1:0] row;
    } ctrl_t;

endpackage
`default_nettype wire

/* sv/sparse_matvec_row_mac_core.sv */
// Channel  | Role   | Handshake          | Payload
// ---------+--------+--------------------+------------------------------
// req      | input  | req_valid/req_stall| smrm_pkg::req_t (load/nonzero)
// rsp      | output | rsp_valid/rsp_stall| smrm_pkg::rsp_t (one per nonzero)
//
// One item accepted per cycle while req_stall is low; a nonzero's rsp_valid
// rises after vector read, product register and accumulation into output register.
// Load items produce no result and finish at their transfer.
// Reset clears row state, the running sum, pipeline valids and vector valid bits.
// A stalled result holds; empty stages keep filling, so req_stall rises only
// once every stage holds a waiting item.
`default_nettype none
module sparse_matvec_row_mac_core #(
    parameter int VEC_LEN = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire smrm_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output smrm_pkg::rsp_t      rsp
);
    import smrm_pkg::*;

    localparam int ROW_W = $clog2(VEC_LEN);

    logic                    req_acc;
    logic                    nz_acc;
    logic                    ld_acc;

    logic [ROWLEN_W-1:0]     rows_left_reg;
    logic [ROW_W-1:0]        current_row_reg;
    logic [ROW_W-1:0]        next_row_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic                    row_open;
    logic                    bad;
    logic                    open_new;
    logic [ROWLEN_W-1:0]     left_base;
    logic [ROWLEN_W-1:0]     left_after;
    logic [ROW_W-1:0]        row_sel;
    logic [ROW_W+ROWIDX_W-1:0] row_wide;
    ctrl_t                   ctrl_next;

    logic                    s1_valid_reg;
    ctrl_t                   s1_ctrl_reg;
    logic signed [VAL_W-1:0] s1_mat_reg;
    logic signed [VAL_W-1:0] vec_rd;

    logic                    s2_valid_reg;
    ctrl_t                   s2_ctrl_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic                    rsp_valid_reg;
    rsp_t                    rsp_reg;
    logic signed [SUM_W-1:0] sum_base;
    logic signed [SUM_W-1:0] sum_next;

    logic                    s1_rdy;
    logic                    s2_rdy;
    logic                    s3_rdy;

    assign s3_rdy    = !rsp_valid_reg || !rsp_stall;
    assign s2_rdy    = !s2_valid_reg || s3_rdy;
    assign s1_rdy    = !s1_valid_reg || s2_rdy;
    assign req_stall = !s1_rdy;

    assign req_acc = req_valid && !req_stall;
    assign nz_acc  = req_acc && (req.req_type == REQ_NONZERO);
    assign ld_acc  = req_acc && (req.req_type == REQ_LOAD);

    always_comb
    begin
        row_open   = rows_left_reg != '0;
        bad        = !row_open && (req.row_len == '0);
        open_new   = !row_open && !bad;
        left_base  = open_new ? req.row_len : rows_left_reg;
        left_after = left_base - ROWLEN_W'(1);
        row_sel    = open_new ? next_row_reg : current_row_reg;
        row_wide   = {{ROWIDX_W{1'b0}}, row_sel};
        ctrl_next.clear = open_new;
        ctrl_next.bad   = bad;
        ctrl_next.done  = !bad && (left_after == '0);
        ctrl_next.row   = bad ? '0 : row_wide[ROWIDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_left_reg   <= '0;
            current_row_reg <= '0;
            next_row_reg    <= '0;
        end
        else if (nz_acc && !bad)
        begin
            rows_left_reg <= left_after;
            if (open_new)
            begin
                current_row_reg <= next_row_reg;
                next_row_reg    <= (next_row_reg == ROW_W'(VEC_LEN - 1)) ? '0
                                   : next_row_reg + ROW_W'(1);
            end
        end
    end

    smrm_vec_store u_vec_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ld_acc),
        .wr_addr (req.vec_index),
        .wr_data (req.vec_value),
        .rd_en   (nz_acc),
        .rd_addr (req.mat_col),
        .rd_data (vec_rd)
    );

    // stage 1: vector element read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_rdy)
        begin
            s1_valid_reg <= nz_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && nz_acc)
        begin
            s1_ctrl_reg <= ctrl_next;
            s1_mat_reg  <= req.mat_value;
        end
    end

    // stage 2: product
    assign prod_next = s1_mat_reg * vec_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_rdy)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy && s1_valid_reg)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_prod_reg <= prod_next;
        end
    end

    // stage 3: accumulate into the result register
    always_comb
    begin
        sum_base = s2_ctrl_reg.clear ? '0 : sum_reg;
        sum_next = sum_base + {{(SUM_W-PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else if (s3_rdy)
        begin
            rsp_valid_reg <= s2_valid_reg;
            if (s2_valid_reg && !s2_ctrl_reg.bad)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy && s2_valid_reg)
        begin
            rsp_reg.row_id      <= s2_ctrl_reg.row;
            rsp_reg.partial_sum <= s2_ctrl_reg.bad ? '0 : sum_next;
            rsp_reg.row_done    <= s2_ctrl_reg.done;
            rsp_reg.bad_row_len <= s2_ctrl_reg.bad;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "sparse_matvec_row_mac_core_assert.svh"

    `SMRM_ASSERT_SAME(a_bad_fields_zero, rsp_valid && rsp.bad_row_len, (rsp.partial_sum == '0) && !rsp.row_done && (rsp.row_id == '0))
    `SMRM_ASSERT_NEXT(a_load_keeps_row, ld_acc, rows_left_reg == $past(rows_left_reg))
    `SMRM_ASSERT_NEXT(a_open_sets_count, nz_acc && (rows_left_reg == '0) && (req.row_len != '0), rows_left_reg == $past(req.row_len) - ROWLEN_W'(1))

endmodule
`default_nettype wire

/* sv/smrm_vec_store.sv */
`default_nettype none
module smrm_vec_store (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [smrm_pkg::VEC_AW-1:0]      wr_addr,
    input  wire logic signed [smrm_pkg::VAL_W-1:0] wr_data,
    input  wire logic                             rd_en,
    input  wire logic [smrm_pkg::VEC_AW-1:0]      rd_addr,
    output logic signed [smrm_pkg::VAL_W-1:0]     rd_data
);
    import smrm_pkg::*;

    logic signed [VAL_W-1:0] mem [VEC_DEPTH];
    logic [VEC_DEPTH-1:0]    valid_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire
